/* rtl/core/csc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

  localparam logic [31:0] SecsPerDay   = 32'd86400;
  localparam logic [16:0] DivDay       = 17'd86400;
  localparam logic [16:0] DivGroup     = 17'd1461;
  localparam logic [16:0] DivHour      = 17'd3600;
  localparam logic [16:0] DivMinute    = 17'd60;
  localparam logic [11:0] YearFirst    = 12'd1970;
  localparam logic [11:0] YearLast     = 12'd2099;
  localparam logic [11:0] YearBase     = 12'd1969;
  localparam logic [15:0] DaysPerYear  = 16'd365;
  localparam logic [31:0] SecsPerHour  = 32'd3600;
  localparam logic [31:0] SecsPerMin   = 32'd60;

  // Reciprocals for quotient = (x * recip) >> shift
  localparam logic [25:0] RecipDay     = 26'd50903317;  // x = dividend >> 7, shift 35
  localparam logic [25:0] RecipGroup   = 26'd91868;     // x = dividend, shift 27
  localparam logic [25:0] RecipHour    = 26'd9321;      // x = dividend >> 4, shift 21
  localparam logic [25:0] RecipMinute  = 26'd1093;      // x = dividend >> 2, shift 14

  // Which division the shared divider performs
  typedef enum logic [1:0] {
    SEL_DAY  = 2'd0,
    SEL_GRP  = 2'd1,
    SEL_HOUR = 2'd2,
    SEL_MIN  = 2'd3
  } csc_div_sel_e;

  typedef struct packed {
    logic         load;
    logic         c0_days;
    logic         c0_mul;
    logic         c0_sum;
    logic         div_start;
    logic         div_take;
    csc_div_sel_e div_sel;
    logic         yr_step;
    logic         mon_step;
    logic         out_load;
  } csc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic yr_more;
    logic mon_more;
  } csc_sts_t;

  // Days before the first of a month (index is month - 1) in a common year
  function automatic logic [8:0] days_before_month(input logic [3:0] idx);
    logic [8:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Length of a month (index 0 is January)
  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] l;
    case (idx) inside
      4'd1:                   l = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: l = 5'd30;
      default:                l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/csc_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Division by one of four constant divisors through a reciprocal multiply.
// Steps after start: multiply, take the quotient, form the remainder.
module csc_div
  import csc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire csc_div_sel_e sel_i,
  input  wire logic [31:0]  dividend_i,
  output logic              done_o,
  output logic [15:0]       quot_o,
  output logic [16:0]       rem_o
);

  localparam logic [1:0] StepIdle = 2'd0;
  localparam logic [1:0] StepRem  = 2'd1;
  localparam logic [1:0] StepQuo  = 2'd2;
  localparam logic [1:0] StepMul  = 2'd3;

  logic [1:0]   step_q, step_d;
  logic         done_q, done_d;
  csc_div_sel_e sel_q;
  logic [31:0]  dvd_q;
  logic [50:0]  prod_q;
  logic [15:0]  quo_q;
  logic [16:0]  rem_q;
  logic [24:0]  mul_a;
  logic [25:0]  mul_b;
  logic [15:0]  quo_calc;
  logic [16:0]  dsr;

  // x drops the divisor's power-of-two factor; the reciprocal error stays
  // below one over each dividend's range, so the quotient is exact
  always_comb begin
    case (sel_q)
      SEL_DAY: begin
        mul_a    = dvd_q[31:7];
        mul_b    = RecipDay;
        quo_calc = prod_q[50:35];
        dsr      = DivDay;
      end
      SEL_GRP: begin
        mul_a    = {9'b0, dvd_q[15:0]};
        mul_b    = RecipGroup;
        quo_calc = prod_q[42:27];
        dsr      = DivGroup;
      end
      SEL_HOUR: begin
        mul_a    = {12'b0, dvd_q[16:4]};
        mul_b    = RecipHour;
        quo_calc = prod_q[36:21];
        dsr      = DivHour;
      end
      default: begin
        mul_a    = {15'b0, dvd_q[11:2]};
        mul_b    = RecipMinute;
        quo_calc = prod_q[29:14];
        dsr      = DivMinute;
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    done_d = done_q;
    if (start_i) begin
      step_d = StepMul;
      done_d = 1'b0;
    end else if (step_q != StepIdle) begin
      step_d = step_q - 2'd1;
      if (step_q == StepRem) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      sel_q <= sel_i;
    end
    if (step_q == StepMul) begin
      prod_q <= {26'b0, mul_a} * {25'b0, mul_b};
    end
    if (step_q == StepQuo) begin
      quo_q <= quo_calc;
    end
    if (step_q == StepRem) begin
      rem_q <= 17'(dvd_q - ({16'b0, quo_q} * {15'b0, dsr}));
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* rtl/core/csc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module csc_datapath
  import csc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire csc_cmd_t    cmd_i,
  output csc_sts_t         sts_o,
  input  wire logic        command_i,
  input  wire logic [31:0] seconds_count_i,
  input  wire logic [11:0] year_i,
  input  wire logic [3:0]  month_i,
  input  wire logic [4:0]  day_i,
  input  wire logic [4:0]  hour_i,
  input  wire logic [5:0]  minute_i,
  input  wire logic [5:0]  second_i,
  output logic [31:0]      count_out_o,
  output logic [11:0]      year_out_o,
  output logic [3:0]       month_out_o,
  output logic [4:0]       day_out_o,
  output logic [4:0]       hour_out_o,
  output logic [5:0]       minute_out_o,
  output logic [5:0]       second_out_o,
  output logic             valid_res_o
);

  // captured transaction
  logic        cmd_q;
  logic        ok_q;
  logic [31:0] secs_q;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;

  // working registers
  logic [15:0] days_q;
  logic [31:0] prod_q;
  logic [31:0] count_q;
  logic [16:0] sod_q;
  logic [5:0]  grp_q;
  logic [10:0] rem_q;
  logic [1:0]  yidx_q;
  logic [3:0]  midx_q;
  logic [4:0]  hr_q;
  logic [11:0] msec_q;
  logic [5:0]  mn_q;
  logic [5:0]  sc_q;

  // result registers
  logic [31:0] count_out_q;
  logic [11:0] year_out_q;
  logic [3:0]  month_out_q;
  logic [4:0]  day_out_q;
  logic [4:0]  hour_out_q;
  logic [5:0]  minute_out_q;
  logic [5:0]  second_out_q;
  logic        valid_res_q;

  logic        in_range;
  logic [11:0] yoff;
  logic [11:0] ydiff;
  logic        leap_fix;
  logic [15:0] days_calc;
  logic [31:0] sum_calc;
  logic        leap_yr;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  logic [31:0] div_dvd;
  logic        div_done;
  logic [15:0] div_quot;
  logic [16:0] div_rem;

  assign in_range = (year_i >= YearFirst) && (year_i <= YearLast) &&
                    (month_i >= 4'd1) && (month_i <= 4'd12);

  // calendar to count
  assign yoff     = year_q - YearFirst;
  assign ydiff    = year_q - YearBase;
  assign leap_fix = (year_q[1:0] == 2'd0) && (month_q >= 4'd3);
  assign days_calc = ({8'b0, yoff[7:0]} * DaysPerYear) + {6'b0, ydiff[11:2]}
                   + {7'b0, days_before_month(month_q - 4'd1)}
                   + {11'b0, day_q} + {15'b0, leap_fix};
  assign sum_calc = prod_q - SecsPerDay + ({27'b0, hour_q} * SecsPerHour)
                  + ({26'b0, minute_q} * SecsPerMin) + {26'b0, second_q};

  // count to calendar: third year of each group is the leap year
  assign leap_yr = (yidx_q == 2'd2);
  assign ylen    = leap_yr ? 9'd366 : 9'd365;
  assign mlen    = month_len(midx_q, leap_yr);

  assign sts_o.div_done = div_done;
  assign sts_o.yr_more  = (yidx_q != 2'd3) && (rem_q >= {2'b0, ylen});
  assign sts_o.mon_more = rem_q >= {6'b0, mlen};

  always_comb begin
    case (cmd_i.div_sel)
      SEL_DAY:  div_dvd = secs_q;
      SEL_GRP:  div_dvd = {16'b0, days_q};
      SEL_HOUR: div_dvd = {15'b0, sod_q};
      default:  div_dvd = {20'b0, msec_q};
    endcase
  end

  csc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .sel_i      (cmd_i.div_sel),
    .dividend_i (div_dvd),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q    <= command_i;
      ok_q     <= in_range;
      secs_q   <= seconds_count_i;
      year_q   <= year_i;
      month_q  <= month_i;
      day_q    <= day_i;
      hour_q   <= hour_i;
      minute_q <= minute_i;
      second_q <= second_i;
    end
    if (cmd_i.c0_days) begin
      days_q <= days_calc;
    end
    if (cmd_i.c0_mul) begin
      prod_q <= {16'b0, days_q} * SecsPerDay;
    end
    if (cmd_i.c0_sum) begin
      count_q <= sum_calc;
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        SEL_DAY: begin
          days_q <= div_quot;
          sod_q  <= div_rem;
        end
        SEL_GRP: begin
          grp_q  <= div_quot[5:0];
          rem_q  <= div_rem[10:0];
          yidx_q <= 2'd0;
          midx_q <= 4'd0;
        end
        SEL_HOUR: begin
          hr_q   <= div_quot[4:0];
          msec_q <= div_rem[11:0];
        end
        default: begin
          mn_q <= div_quot[5:0];
          sc_q <= div_rem[5:0];
        end
      endcase
    end
    if (cmd_i.yr_step) begin
      rem_q  <= rem_q - {2'b0, ylen};
      yidx_q <= yidx_q + 2'd1;
    end
    if (cmd_i.mon_step) begin
      rem_q  <= rem_q - {6'b0, mlen};
      midx_q <= midx_q + 4'd1;
    end
    if (cmd_i.out_load) begin
      if (!cmd_q) begin
        count_out_q  <= ok_q ? count_q : 32'd0;
        year_out_q   <= '0;
        month_out_q  <= '0;
        day_out_q    <= '0;
        hour_out_q   <= '0;
        minute_out_q <= '0;
        second_out_q <= '0;
        valid_res_q  <= ok_q;
      end else begin
        count_out_q  <= '0;
        year_out_q   <= YearFirst + {4'b0, grp_q, 2'b0} + {10'b0, yidx_q};
        month_out_q  <= midx_q + 4'd1;
        day_out_q    <= rem_q[4:0] + 5'd1;
        hour_out_q   <= hr_q;
        minute_out_q <= mn_q;
        second_out_q <= sc_q;
        valid_res_q  <= 1'b1;
      end
    end
  end

  assign count_out_o  = count_out_q;
  assign year_out_o   = year_out_q;
  assign month_out_o  = month_out_q;
  assign day_out_o    = day_out_q;
  assign hour_out_o   = hour_out_q;
  assign minute_out_o = minute_out_q;
  assign second_out_o = second_out_q;
  assign valid_res_o  = valid_res_q;

endmodule

`default_nettype wire

/* rtl/core/csc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module csc_ctrl
  import csc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic     command_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output csc_cmd_t      cmd_o,
  input  wire csc_sts_t sts_i
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_C0_DAYS   = 4'd1;
  localparam logic [3:0] S_C0_MUL    = 4'd2;
  localparam logic [3:0] S_C0_SUM    = 4'd3;
  localparam logic [3:0] S_DAY_GO    = 4'd4;
  localparam logic [3:0] S_DAY_WAIT  = 4'd5;
  localparam logic [3:0] S_GRP_GO    = 4'd6;
  localparam logic [3:0] S_GRP_WAIT  = 4'd7;
  localparam logic [3:0] S_YEAR      = 4'd8;
  localparam logic [3:0] S_MON       = 4'd9;
  localparam logic [3:0] S_HOUR_GO   = 4'd10;
  localparam logic [3:0] S_HOUR_WAIT = 4'd11;
  localparam logic [3:0] S_MIN_GO    = 4'd12;
  localparam logic [3:0] S_MIN_WAIT  = 4'd13;
  localparam logic [3:0] S_DONE      = 4'd14;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = SEL_DAY;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = command_i ? S_DAY_GO : S_C0_DAYS;
        end
      end
      S_C0_DAYS: begin
        cmd_o.c0_days = 1'b1;
        state_d       = S_C0_MUL;
      end
      S_C0_MUL: begin
        cmd_o.c0_mul = 1'b1;
        state_d      = S_C0_SUM;
      end
      S_C0_SUM: begin
        cmd_o.c0_sum = 1'b1;
        state_d      = S_DONE;
      end
      S_DAY_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DAY_WAIT;
      end
      S_DAY_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_GRP_GO;
        end
      end
      S_GRP_GO: begin
        cmd_o.div_sel   = SEL_GRP;
        cmd_o.div_start = 1'b1;
        state_d         = S_GRP_WAIT;
      end
      S_GRP_WAIT: begin
        cmd_o.div_sel = SEL_GRP;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_YEAR;
        end
      end
      S_YEAR: begin
        if (sts_i.yr_more) begin
          cmd_o.yr_step = 1'b1;
        end else begin
          state_d = S_MON;
        end
      end
      S_MON: begin
        if (sts_i.mon_more) begin
          cmd_o.mon_step = 1'b1;
        end else begin
          state_d = S_HOUR_GO;
        end
      end
      S_HOUR_GO: begin
        cmd_o.div_sel   = SEL_HOUR;
        cmd_o.div_start = 1'b1;
        state_d         = S_HOUR_WAIT;
      end
      S_HOUR_WAIT: begin
        cmd_o.div_sel = SEL_HOUR;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_MIN_GO;
        end
      end
      S_MIN_GO: begin
        cmd_o.div_sel   = SEL_MIN;
        cmd_o.div_start = 1'b1;
        state_d         = S_MIN_WAIT;
      end
      S_MIN_WAIT: begin
        cmd_o.div_sel = SEL_MIN;
        if (sts_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        // result register free, or emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/calendar_seconds_converter_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Calendar date/time <-> seconds since 1970-01-01 00:00, years 1970..2099.
// Input channel (in_valid_i/in_ready_o) carries command_i and both operand
// sets; command 0 turns the calendar fields into a count, command 1 turns
// seconds_count_i into a calendar date. Output channel (out_valid_o/
// out_ready_i) returns one result transaction per input transaction.
// One transaction is processed at a time; in_ready_o is high while idle.
// From acceptance to out_valid_o, command 0 computes the days,
// multiplies them by 86400, forms the sum and hands off. Command 1 runs
// four constant divisions (each a start, three reciprocal-multiply
// steps and a take), a year walk, a month walk and the hand-off. The next
// transaction is accepted in the cycle after the hand-off, so the block
// never takes a new transaction while one is still in work.
// The result sits in an output register; a new transaction is accepted
// while it waits, and a finished one waits until that register is free,
// so a stalled receiver only holds back the hand-off, never loses data.
// Reset (rst_ni low, asynchronous) returns the controller to idle and
// drops out_valid_o.
module calendar_seconds_converter_top
  import csc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [31:0] seconds_count_i,
  input  wire logic [11:0] year_i,
  input  wire logic [3:0]  month_i,
  input  wire logic [4:0]  day_i,
  input  wire logic [4:0]  hour_i,
  input  wire logic [5:0]  minute_i,
  input  wire logic [5:0]  second_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      count_out_o,
  output logic [11:0]      year_out_o,
  output logic [3:0]       month_out_o,
  output logic [4:0]       day_out_o,
  output logic [4:0]       hour_out_o,
  output logic [5:0]       minute_out_o,
  output logic [5:0]       second_out_o,
  output logic             valid_res_o
);

  csc_cmd_t cmd;
  csc_sts_t sts;

  csc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  csc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .command_i       (command_i),
    .seconds_count_i (seconds_count_i),
    .year_i          (year_i),
    .month_i         (month_i),
    .day_i           (day_i),
    .hour_i          (hour_i),
    .minute_i        (minute_i),
    .second_i        (second_i),
    .count_out_o     (count_out_o),
    .year_out_o      (year_out_o),
    .month_out_o     (month_out_o),
    .day_out_o       (day_out_o),
    .hour_out_o      (hour_out_o),
    .minute_out_o    (minute_out_o),
    .second_out_o    (second_out_o),
    .valid_res_o     (valid_res_o)
  );

endmodule

`default_nettype wire
